[design/utf8_to_legacy_text_folder_defines.svh]
// Assertion macros used by the bound checker module u2lt_checker.
`ifndef UTF8_TO_LEGACY_TEXT_FOLDER_DEFINES_SVH
`define UTF8_TO_LEGACY_TEXT_FOLDER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define U2LT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u2lt check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define U2LT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u2lt check failed");

`endif

[design/u2lt_pkg.sv]
package u2lt_pkg;

  // Configuration register indexes
  localparam logic CfgTextMode = 1'b0;
  localparam logic CfgMaskKey  = 1'b1;

  localparam logic [7:0] MaskKeyReset = 8'h77;
  localparam int         QueueDepth   = 4;

  localparam logic [20:0] FullwidthOffset = 21'h00FEE0;
  localparam logic [20:0] FullwidthFirst  = 21'h00FF01;
  localparam logic [20:0] FullwidthLast   = 21'h00FF5E;
  localparam logic [7:0]  Unknown         = 8'h3F;

  // One queued job: up to three text bytes plus an optional terminator,
  // all bytes already masked.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      nb;
    logic            term;
    logic [7:0]      term_byte;
  } job_t;

  typedef struct packed {
    logic       text_mode;
    logic [7:0] mask_key;
  } cfg_t;

  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      cnt;
  } fold_t;

  function automatic fold_t fold_cp(input logic [20:0] cp);
    fold_t r;
    r.data = '0;
    r.cnt  = 2'd1;
    unique case (cp)
      21'h2018, 21'h2019: r.data[0] = 8'h27;
      21'h201C, 21'h201D: r.data[0] = 8'h22;
      21'h2013: r.data[0] = 8'h2D;
      21'h2014: begin
        r.data[0] = 8'h2D; r.data[1] = 8'h2D; r.cnt = 2'd2;
      end
      21'h2026: begin
        r.data[0] = 8'h2E; r.data[1] = 8'h2E; r.data[2] = 8'h2E; r.cnt = 2'd3;
      end
      21'h3000: begin
        r.data[0] = 8'h81; r.data[1] = 8'h40; r.cnt = 2'd2;
      end
      21'h00A0: r.data[0] = 8'h20;
      21'h00D7: begin
        r.data[0] = 8'h81; r.data[1] = 8'h7E; r.cnt = 2'd2;
      end
      21'h2190: begin
        r.data[0] = 8'h81; r.data[1] = 8'hA9; r.cnt = 2'd2;
      end
      21'h2191: begin
        r.data[0] = 8'h81; r.data[1] = 8'hAA; r.cnt = 2'd2;
      end
      21'h2192: begin
        r.data[0] = 8'h81; r.data[1] = 8'hA8; r.cnt = 2'd2;
      end
      21'h2193: begin
        r.data[0] = 8'h81; r.data[1] = 8'hAB; r.cnt = 2'd2;
      end
      21'h2605: begin
        r.data[0] = 8'h81; r.data[1] = 8'h9A; r.cnt = 2'd2;
      end
      21'h2606: begin
        r.data[0] = 8'h81; r.data[1] = 8'h99; r.cnt = 2'd2;
      end
      21'h266A: begin
        r.data[0] = 8'h81; r.data[1] = 8'hF4; r.cnt = 2'd2;
      end
      21'h30FB: begin
        r.data[0] = 8'h81; r.data[1] = 8'h45; r.cnt = 2'd2;
      end
      default: begin
        if (cp >= FullwidthFirst && cp <= FullwidthLast) begin
          r.data[0] = 8'(cp - FullwidthOffset);
        end else begin
          r.data[0] = Unknown;
        end
      end
    endcase
    return r;
  endfunction

endpackage

[design/u2lt_if.sv]
interface u2lt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, in_byte, last_byte, input ready);
  modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

interface u2lt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       is_terminator;

  modport source (output valid, out_byte, run_end, is_terminator, input ready);
  modport sink   (input valid, out_byte, run_end, is_terminator, output ready);
endinterface

[design/u2lt_queue.sv]
module u2lt_queue #(
  parameter int Depth = u2lt_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  u2lt_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output u2lt_pkg::job_t head_job,
  output logic           empty
);
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  DepthCnt = CntW'(Depth);

  u2lt_pkg::job_t   jobs [Depth];
  logic [AddrW-1:0] wr_ptr;
  logic [AddrW-1:0] rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == DepthCnt);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = jobs[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      jobs[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastAddr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastAddr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

[design/u2lt_front.sv]
module u2lt_front (
  input  logic           clk,
  input  logic           rst,
  input  u2lt_pkg::cfg_t cfg,
  u2lt_in_if.sink        utf8,
  input  logic           queue_full,
  output logic           push,
  output u2lt_pkg::job_t push_job
);
  logic [1:0]      bytes_pending;
  logic [1:0]      bytes_pending_next;
  logic [20:0]     code_accum;
  logic [20:0]     code_accum_next;
  logic [7:0]      c;
  logic            last;
  logic [20:0]     accum_shift;
  logic [1:0]      pend_dec;
  logic [20:0]     lead_bits;
  logic [1:0]      lead_pend;
  logic            lead_ok;
  logic [20:0]     fold_arg;
  u2lt_pkg::fold_t folded;
  logic [2:0][7:0] raw;
  logic [1:0]      nb;
  logic [7:0]      key;
  logic            accept;

  assign c           = utf8.in_byte;
  assign last        = utf8.last_byte;
  assign utf8.ready  = !queue_full;
  assign accept      = utf8.valid && !queue_full;
  assign accum_shift = {code_accum[14:0], c[5:0]};
  assign pend_dec    = bytes_pending - 2'd1;
  assign key         = cfg.text_mode ? cfg.mask_key : 8'h00;

  // Lead byte length decode
  always_comb begin
    lead_bits = '0;
    lead_pend = 2'd0;
    lead_ok   = 1'b1;
    priority if (c[7:5] == 3'b110) begin
      lead_bits = {16'b0, c[4:0]};
      lead_pend = 2'd1;
    end else if (c[7:4] == 4'b1110) begin
      lead_bits = {17'b0, c[3:0]};
      lead_pend = 2'd2;
    end else if (c[7:3] == 5'b11110) begin
      lead_bits = {18'b0, c[2:0]};
      lead_pend = 2'd3;
    end else begin
      lead_ok = 1'b0;
    end
  end

  assign fold_arg = (bytes_pending != 2'd0) ? accum_shift : lead_bits;
  assign folded   = u2lt_pkg::fold_cp(fold_arg);

  always_comb begin
    bytes_pending_next = bytes_pending;
    code_accum_next    = code_accum;
    raw                = '0;
    nb                 = 2'd0;
    if (!cfg.text_mode) begin
      bytes_pending_next = 2'd0;
      code_accum_next    = '0;
      raw[0]             = c;
      nb                 = 2'd1;
    end else if (bytes_pending != 2'd0) begin
      code_accum_next    = accum_shift;
      bytes_pending_next = pend_dec;
      if (pend_dec == 2'd0 || last) begin
        raw = folded.data;
        nb  = folded.cnt;
      end
    end else if (!c[7]) begin
      raw[0] = c;
      nb     = 2'd1;
    end else if (!lead_ok) begin
      raw[0] = u2lt_pkg::Unknown;
      nb     = 2'd1;
    end else begin
      code_accum_next    = lead_bits;
      bytes_pending_next = lead_pend;
      if (last) begin
        raw = folded.data;
        nb  = folded.cnt;
      end
    end
    if (last) begin
      bytes_pending_next = 2'd0;
      code_accum_next    = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      push_job.data[i] = raw[i] ^ key;
    end
    push_job.nb        = nb;
    push_job.term      = last;
    push_job.term_byte = key;
  end

  // Drop mid-sequence bytes that give nothing
  assign push = accept && (nb != 2'd0 || last);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      code_accum    <= '0;
    end else if (accept) begin
      bytes_pending <= bytes_pending_next;
      code_accum    <= code_accum_next;
    end
  end
endmodule

[design/u2lt_back.sv]
module u2lt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  u2lt_pkg::job_t head_job,
  output logic           pop,
  u2lt_out_if.source     legacy
);
  logic       out_valid;
  logic [7:0] out_byte;
  logic       run_end;
  logic       is_terminator;
  logic [1:0] idx;
  logic [2:0] total;
  logic       final_res;
  logic       is_data;
  logic [7:0] data_sel;
  logic       advance;

  assign total     = {1'b0, head_job.nb} + {2'b00, head_job.term};
  assign final_res = ({1'b0, idx} == total - 3'd1);
  assign is_data   = (idx < head_job.nb);
  assign advance   = head_valid && (!out_valid || legacy.ready);
  assign pop       = advance && final_res;

  always_comb begin
    unique case (idx)
      2'd0:    data_sel = head_job.data[0];
      2'd1:    data_sel = head_job.data[1];
      2'd2:    data_sel = head_job.data[2];
      default: data_sel = head_job.term_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= final_res ? 2'd0 : idx + 2'd1;
      end else if (legacy.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte      <= is_data ? data_sel : head_job.term_byte;
      run_end       <= final_res;
      is_terminator <= !is_data;
    end
  end

  assign legacy.valid         = out_valid;
  assign legacy.out_byte      = out_byte;
  assign legacy.run_end       = run_end;
  assign legacy.is_terminator = is_terminator;
endmodule

[design/utf8_to_legacy_text_folder.sv]
// Path: an input transfer writes its job into the job queue, and the back then loads
//   the job's first result into the output register, from which it transfers.
// Throughput: one input byte per cycle while each byte gives one result; a byte that
//   gives several results holds the output for one transfer per result, and the job queue (QueueDepth
//   entries) absorbs the burst before the input stalls. The output port sets the rate.
// Reset (rst, synchronous, active high): empties the queue, drops any partial sequence,
//   sets text_mode to 1 and mask_key to 0x77.
module utf8_to_legacy_text_folder #(
  parameter int QueueDepth = u2lt_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  u2lt_in_if.sink    utf8,
  u2lt_out_if.source legacy
);
  // Configuration registers; the user must write them only while the block is idle, which the block leaves unchecked.
  u2lt_pkg::cfg_t cfg;

  // Queue between front (decode and fold) and back (serialize results).
  logic           push;
  u2lt_pkg::job_t push_job;
  logic           queue_full;
  logic           pop;
  u2lt_pkg::job_t head_job;
  logic           queue_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_mode <= 1'b1;
      cfg.mask_key  <= u2lt_pkg::MaskKeyReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        u2lt_pkg::CfgTextMode: cfg.text_mode <= cfg_data[0];
        u2lt_pkg::CfgMaskKey:  cfg.mask_key  <= cfg_data;
      endcase
    end
  end

  // Front: take one byte per transfer; in text mode, track the pending sequence, fold a
  // finished code point and mask it. Each byte that yields output becomes one job.
  u2lt_front front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .utf8       (utf8),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  // Hold jobs so the front keeps taking bytes while the back drains an expansion.
  u2lt_queue #(
    .Depth (QueueDepth)
  ) queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (queue_empty)
  );

  // Back: emit a job's bytes one per transfer, then the terminator if any;
  // flag run_end on the final one and release the job.
  u2lt_back back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!queue_empty),
    .head_job   (head_job),
    .pop        (pop),
    .legacy     (legacy)
  );
endmodule

[design/u2lt_checker.sv]
`include "utf8_to_legacy_text_folder_defines.svh"

module u2lt_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic out_run_end,
  input logic out_is_terminator
);
  `U2LT_ASSERT_NEXT(a_hold_valid, clk, rst, out_valid && !out_ready, out_valid)
  `U2LT_ASSERT_NOW(a_term_ends_run, clk, rst, out_valid && out_is_terminator, out_run_end)
  `U2LT_ASSERT_NEXT(a_idle_after_reset, clk, rst, $fell(rst), !out_valid)
endmodule

bind utf8_to_legacy_text_folder u2lt_checker checker_inst (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (legacy.valid),
  .out_ready         (legacy.ready),
  .out_run_end       (legacy.run_end),
  .out_is_terminator (legacy.is_terminator)
);

[tb/sv/legacy_text_checker.sv]
`timescale 1ns / 100ps

module legacy_text_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  u2lt_in_if         utf8,
  u2lt_out_if        legacy,
  output int         fail_count,
  output int         awaiting,
  output int         results_checked
);

  localparam logic [20:0] FullwidthStart = 21'h00FF01;
  localparam logic [20:0] FullwidthEnd   = 21'h00FF5E;
  localparam logic [20:0] FullwidthShift = 21'h00FEE0;
  localparam logic [7:0]  QuestionMark   = 8'h3F;
  localparam logic [7:0]  SjisLead       = 8'h81;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       is_terminator;
  } legacy_byte_t;

  legacy_byte_t expected_bytes[$];

  logic        text_mode;
  logic [7:0]  mask_key;
  logic [1:0]  seq_left;
  logic [20:0] code_point;

  // Map one code point to its legacy byte string; return the byte count.
  function automatic int legacy_bytes_for(input logic [20:0] cp,
                                          output logic [2:0][7:0] seq);
    int cnt;
    seq = '0;
    cnt = 1;
    case (cp)
      21'h2018, 21'h2019: seq[0] = 8'h27;
      21'h201C, 21'h201D: seq[0] = 8'h22;
      21'h2013: seq[0] = 8'h2D;
      21'h2014: begin
        seq[0] = 8'h2D; seq[1] = 8'h2D; cnt = 2;
      end
      21'h2026: begin
        seq[0] = 8'h2E; seq[1] = 8'h2E; seq[2] = 8'h2E; cnt = 3;
      end
      21'h00A0: seq[0] = 8'h20;
      21'h3000: begin seq[0] = SjisLead; seq[1] = 8'h40; cnt = 2; end
      21'h00D7: begin seq[0] = SjisLead; seq[1] = 8'h7E; cnt = 2; end
      21'h2190: begin seq[0] = SjisLead; seq[1] = 8'hA9; cnt = 2; end
      21'h2191: begin seq[0] = SjisLead; seq[1] = 8'hAA; cnt = 2; end
      21'h2192: begin seq[0] = SjisLead; seq[1] = 8'hA8; cnt = 2; end
      21'h2193: begin seq[0] = SjisLead; seq[1] = 8'hAB; cnt = 2; end
      21'h2605: begin seq[0] = SjisLead; seq[1] = 8'h9A; cnt = 2; end
      21'h2606: begin seq[0] = SjisLead; seq[1] = 8'h99; cnt = 2; end
      21'h266A: begin seq[0] = SjisLead; seq[1] = 8'hF4; cnt = 2; end
      21'h30FB: begin seq[0] = SjisLead; seq[1] = 8'h45; cnt = 2; end
      default: begin
        if (cp >= FullwidthStart && cp <= FullwidthEnd) begin
          seq[0] = 8'(cp - FullwidthShift);
        end else begin
          seq[0] = QuestionMark;
        end
      end
    endcase
    return cnt;
  endfunction

  // Advance the decoder by one input byte and queue the bytes it yields.
  task automatic fold_input_byte(input logic [7:0] c, input logic last);
    logic [7:0]      key;
    logic [2:0][7:0] seq;
    legacy_byte_t    row[4];
    int              n;
    int              cnt;
    int              len;
    int              k;
    key = text_mode ? mask_key : 8'h00;
    n = 0;
    cnt = 0;
    seq = '0;
    if (!text_mode) begin
      seq_left = '0;
      code_point = '0;
      seq[0] = c;
      n = 1;
    end else if (seq_left != 0) begin
      code_point = {code_point[14:0], c[5:0]};
      seq_left = seq_left - 2'd1;
      if (seq_left == 0 || last) n = legacy_bytes_for(code_point, seq);
    end else if (!c[7]) begin
      seq[0] = c;
      n = 1;
    end else begin
      if (c[7:5] == 3'b110) len = 2;
      else if (c[7:4] == 4'b1110) len = 3;
      else if (c[7:3] == 5'b11110) len = 4;
      else len = 1;
      if (len == 1) begin
        seq[0] = QuestionMark;
        n = 1;
      end else begin
        code_point = 21'(c & (8'h7F >> len));
        seq_left = 2'(len - 1);
        if (last) n = legacy_bytes_for(code_point, seq);
      end
    end
    for (k = 0; k < n; k++) begin
      row[cnt].out_byte = seq[k] ^ key;
      row[cnt].run_end = 1'b0;
      row[cnt].is_terminator = 1'b0;
      cnt++;
    end
    if (last) begin
      row[cnt].out_byte = key;
      row[cnt].run_end = 1'b0;
      row[cnt].is_terminator = 1'b1;
      cnt++;
      seq_left = '0;
      code_point = '0;
    end
    if (cnt > 0) row[cnt - 1].run_end = 1'b1;
    for (k = 0; k < cnt; k++) expected_bytes = {expected_bytes, row[k]};
  endtask

  initial begin
    fail_count = 0;
    awaiting = 0;
    results_checked = 0;
    text_mode = 1'b1;
    mask_key = u2lt_pkg::MaskKeyReset;
    seq_left = '0;
    code_point = '0;
  end

  always @(posedge clk) begin
    legacy_byte_t want;
    if (rst) begin
      text_mode = 1'b1;
      mask_key = u2lt_pkg::MaskKeyReset;
      seq_left = '0;
      code_point = '0;
      expected_bytes.delete();
    end else begin
      if (cfg_we === 1'b1) begin
        if (cfg_index == u2lt_pkg::CfgTextMode) text_mode = cfg_data[0];
        else mask_key = cfg_data;
      end
      if (utf8.valid === 1'b1 && utf8.ready === 1'b1) begin
        fold_input_byte(utf8.in_byte, utf8.last_byte);
      end
      if (legacy.valid === 1'b1 && legacy.ready === 1'b1) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte: nothing expected, got %h", legacy.out_byte);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          results_checked++;
          if (legacy.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, legacy.out_byte);
            fail_count++;
          end
          if (legacy.run_end !== want.run_end) begin
            $error("run_end: expected %b, got %b", want.run_end, legacy.run_end);
            fail_count++;
          end
          if (legacy.is_terminator !== want.is_terminator) begin
            $error("is_terminator: expected %b, got %b", want.is_terminator,
                   legacy.is_terminator);
            fail_count++;
          end
        end
      end
    end
    awaiting = expected_bytes.size();
  end

endmodule

[tb/sv/tb_utf8_to_legacy_text_folder.sv]
`timescale 1ns / 100ps

module tb_utf8_to_legacy_text_folder;

  // Run bounds.
  localparam int CycleLimit    = 200000;
  localparam int DrainCycles   = 12;
  localparam int HoldOffCycles = 80;
  localparam int GapPercent    = 21;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  u2lt_in_if  utf8_bus ();
  u2lt_out_if legacy_bus ();

  int fail_count;
  int awaiting;
  int results_checked;

  int bytes_sent = 0;
  int texts_sent = 0;
  int settings_applied = 0;
  int cycle_count = 0;
  int hold_left = 0;

  // Shared knobs between the source and the sink processes.
  bit gaps_on = 1'b1;
  bit hold_request = 1'b0;

  logic [7:0] text_buf[$];

  utf8_to_legacy_text_folder uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .utf8      (utf8_bus),
    .legacy    (legacy_bus)
  );

  legacy_text_checker fold_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .utf8            (utf8_bus),
    .legacy          (legacy_bus),
    .fail_count      (fail_count),
    .awaiting        (awaiting),
    .results_checked (results_checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL utf8_to_legacy_text_folder");
      $finish;
    end
  end

  // Output sink. Drive ready at the falling edge; a hold-off request from the
  // stimulus blocks the port for a counted stretch so the job queue fills and
  // the input stalls behind it.
  initial begin
    legacy_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        legacy_bus.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(99) < GapPercent) begin
        legacy_bus.ready <= 1'b0;
      end else begin
        legacy_bus.ready <= 1'b1;
      end
    end
  end

  // Special code points with a dedicated folding, in no particular order.
  function automatic logic [20:0] folded_point(int k);
    case (k)
      0:       return 21'h2018;
      1:       return 21'h2019;
      2:       return 21'h201C;
      3:       return 21'h201D;
      4:       return 21'h2013;
      5:       return 21'h2014;
      6:       return 21'h2026;
      7:       return 21'h3000;
      8:       return 21'h00A0;
      9:       return 21'h00D7;
      10:      return 21'h2190;
      11:      return 21'h2191;
      12:      return 21'h2192;
      13:      return 21'h2193;
      14:      return 21'h2605;
      15:      return 21'h2606;
      16:      return 21'h266A;
      default: return 21'h30FB;
    endcase
  endfunction

  // Append one byte to the end of the text buffer.
  function automatic void add_byte(logic [7:0] b);
    text_buf = {text_buf, b};
  endfunction

  // Append the UTF-8 encoding of one code point to the text buffer.
  function automatic void append_code_point(logic [20:0] cp);
    if (cp < 21'h80) begin
      add_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endfunction

  // Build one random text. Mostly well-formed characters with random content;
  // the rest is stray continuation or invalid bytes, broken sequences and truncated endings.
  function automatic void build_text();
    int chars;
    int kind;
    int extra;
    int cut;
    text_buf.delete();
    chars = $urandom_range(2, 10);
    for (int i = 0; i < chars; i++) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        add_byte(8'($urandom_range(0, 127)));
      end else if (kind < 60) begin
        append_code_point(folded_point($urandom_range(0, 17)));
      end else if (kind < 72) begin
        // full-width block plus its two neighbors
        append_code_point(21'($urandom_range(21'hFF00, 21'hFF5F)));
      end else if (kind < 84) begin
        case ($urandom_range(2, 4))
          2:       append_code_point(21'($urandom_range(21'h80, 21'h7FF)));
          3:       append_code_point(21'($urandom_range(21'h800, 21'hFFFF)));
          default: append_code_point(21'($urandom_range(21'h10000, 21'h1FFFFF)));
        endcase
      end else if (kind < 92) begin
        if ($urandom_range(1)) add_byte(8'($urandom_range(8'h80, 8'hBF)));
        else add_byte(8'($urandom_range(8'hF8, 8'hFF)));
      end else begin
        // lead byte followed by arbitrary bytes taken as continuations
        add_byte(8'($urandom_range(8'hC0, 8'hF7)));
        extra = $urandom_range(1, 2);
        for (int j = 0; j < extra; j++) add_byte(8'($urandom));
      end
    end
    // Drop a tail now and then so the text can end inside a sequence.
    if ($urandom_range(99) < 15) begin
      cut = $urandom_range(1, 2);
      while (cut > 0 && text_buf.size() > 1) begin
        text_buf = text_buf[0:$-1];
        cut--;
      end
    end
  endfunction

  // Offer one byte and hold it until the block takes it. Returns at the
  // falling edge after the transfer with valid still high.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (gaps_on && $urandom_range(99) < GapPercent) begin
      utf8_bus.valid <= 1'b0;
      @(negedge clk);
    end
    utf8_bus.valid     <= 1'b1;
    utf8_bus.in_byte   <= b;
    utf8_bus.last_byte <= last;
    @(posedge clk);
    while (utf8_bus.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      send_byte(text_buf[i], i == text_buf.size() - 1);
    end
    texts_sent++;
  endtask

  task automatic send_random_texts(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      build_text();
      send_text();
    end
  endtask

  // Drop valid, wait for every expected byte, then let the pipe go quiet.
  task automatic let_settle();
    utf8_bus.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Write both registers back to back while the block is idle.
  task automatic apply_setting(input logic mode, input logic [7:0] key);
    cfg_we    <= 1'b1;
    cfg_index <= u2lt_pkg::CfgTextMode;
    cfg_data  <= {7'd0, mode};
    @(negedge clk);
    cfg_index <= u2lt_pkg::CfgMaskKey;
    cfg_data  <= key;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_applied++;
  endtask

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = u2lt_pkg::CfgTextMode;
    cfg_data           = 8'h00;
    utf8_bus.valid     = 1'b0;
    utf8_bus.in_byte   = 8'h00;
    utf8_bus.last_byte = 1'b0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed text under the reset settings: ASCII extremes, ellipsis, em
    // dash, both ends of the full-width block, a Latin-1 symbol, a stray continuation
    // byte and a stray 0xFF byte, a four-byte sequence, and a text that ends two
    // bytes into a three-byte sequence.
    text_buf = '{8'h41, 8'h00, 8'h7F, 8'hE2, 8'h80, 8'hA6, 8'hE2, 8'h80, 8'h94,
                 8'hEF, 8'hBC, 8'h81, 8'hEF, 8'hBD, 8'h9E, 8'hC3, 8'h97, 8'h80,
                 8'hFF, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE2, 8'h80};
    send_text();
    // A text that is nothing but a lead byte.
    text_buf = '{8'hC2};
    send_text();
    let_settle();

    // No mask, no idling on either side for a long stretch.
    apply_setting(1'b1, 8'h00);
    gaps_on = 1'b0;
    send_random_texts(45);
    let_settle();

    // Full mask with random idling.
    gaps_on = 1'b1;
    apply_setting(1'b1, 8'hFF);
    send_random_texts(40);
    let_settle();

    // Pass mode: bytes go straight through, no terminator mask.
    apply_setting(1'b0, 8'($urandom));
    send_random_texts(30);
    let_settle();

    // Random mask; block the sink while the source keeps offering.
    apply_setting(1'b1, 8'($urandom));
    hold_request = 1'b1;
    send_random_texts(55);
    let_settle();

    $display("Sent %0d bytes in %0d texts under %0d register settings plus reset;",
             bytes_sent, texts_sent, settings_applied);
    $display("checked %0d output bytes, including a long sink stall.", results_checked);
    if (fail_count == 0) begin
      $display("PASS utf8_to_legacy_text_folder");
    end else begin
      $display("FAIL utf8_to_legacy_text_folder");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/u2lt_pkg.sv
design/u2lt_if.sv
design/u2lt_queue.sv
design/u2lt_front.sv
design/u2lt_back.sv
design/utf8_to_legacy_text_folder.sv
design/u2lt_checker.sv
tb/sv/legacy_text_checker.sv
tb/sv/tb_utf8_to_legacy_text_folder.sv
